FILE: rtl/core/htd_pkg.sv
package htd_pkg;
  localparam int NodeCountDef = 512;
  localparam int MaxCodeLengthDef = 16;
  localparam int SymbolWidthDef = 8;

  localparam logic [1:0] OpLoad = 2'd0;
  localparam logic [1:0] OpDecode = 2'd1;
  localparam logic [1:0] OpRestart = 2'd2;
  localparam logic [1:0] OpUnknown = 2'd3;

  localparam logic [1:0] StSymbol = 2'd0;
  localparam logic [1:0] StNone = 2'd1;
  localparam logic [1:0] StAccepted = 2'd2;
  localparam logic [1:0] StError = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic capture;     // latch input transaction, load bit index (code length for a load, zero for a decode)
    logic rd;          // read node table at current node, or at its child during lookahead
    logic step;        // apply read data: advance, allocate, emit
    logic clear;       // clear pass write
    logic restart;     // walk back to root
  } htd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic done;        // item finished after this step
    logic clear_done;
  } htd_stat_t;
endpackage

FILE: rtl/core/htd_datapath.sv
module htd_datapath
  import htd_pkg::*;
#(
  parameter int NODE_COUNT = NodeCountDef,
  parameter int MAX_CODE_LENGTH = MaxCodeLengthDef,
  parameter int SYMBOL_WIDTH = SymbolWidthDef
) (
  input  logic clk,
  input  logic rst,
  input  htd_cmd_t cmd,
  output htd_stat_t stat,
  input  logic [1:0] operation,
  input  logic [7:0] symbol,
  input  logic [15:0] code_bits,
  input  logic [4:0] code_length,
  input  logic [7:0] data_byte,
  input  logic [3:0] valid_bits,
  output logic res_valid,
  output logic [1:0] res_status,
  output logic [7:0] res_symbol,
  output logic res_last
);
  localparam int NW = $clog2(NODE_COUNT);
  localparam int CW = $clog2(NODE_COUNT + 1);
  localparam int LW = $clog2(MAX_CODE_LENGTH + 1) > 5 ? $clog2(MAX_CODE_LENGTH + 1) : 5;
  localparam int SW = SYMBOL_WIDTH;

  logic [NW-1:0] left_mem [NODE_COUNT];
  logic [NW-1:0] right_mem [NODE_COUNT];
  logic [SW-1:0] sym_mem [NODE_COUNT];

  logic [1:0] op;
  logic [SW-1:0] sym;
  logic [15:0] bits;
  logic [LW-1:0] len;
  logic [7:0] dbyte;
  logic [3:0] cnt;
  logic [LW-1:0] idx;
  logic [NW-1:0] node;
  logic [NW-1:0] walk_node;
  logic [CW-1:0] nodes_used;
  logic [NW-1:0] clr_addr;
  logic [NW-1:0] rd_l, rd_r;
  logic [NW-1:0] nx_l, nx_r;
  logic [NW-1:0] pend;  // child found by the first read of a decode bit
  logic lookahead;  // second read for leaf test
  logic held_valid;  // decode result kept back until the next one or the end
  logic [1:0] held_status;
  logic [SW-1:0] held_symbol;
  logic fin;  // walk over, only the held result is left to send

  // clear pass
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end
  assign stat.clear_done = (clr_addr == NW'(NODE_COUNT - 1));

  logic bit_now;
  logic [LW-1:0] bpos;
  logic bad_len;
  logic [NW-1:0] child;
  logic full;
  logic wr_en;
  logic wr_right;
  logic [NW-1:0] wr_addr, wr_data;
  logic leaf;
  logic last_bit;

  assign bpos = idx - LW'(1);
  assign bit_now = (op == OpLoad) ? (bpos < LW'(16) ? bits[bpos[3:0]] : 1'b0)
                                  : dbyte[3'(3'd7 - idx[2:0])];
  assign child = bit_now ? rd_r : rd_l;
  assign full = (nodes_used >= CW'(NODE_COUNT));
  assign bad_len = (len == '0) || (len > LW'(MAX_CODE_LENGTH));

  // address to read: for decode lookahead read the child to test for a leaf
  logic [NW-1:0] rd_addr;
  assign rd_addr = lookahead ? child : node;

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      left_mem[clr_addr] <= '0;
      right_mem[clr_addr] <= '0;
    end else if (wr_en) begin
      if (wr_right) right_mem[wr_addr] <= wr_data;
      else left_mem[wr_addr] <= wr_data;
    end
    if (cmd.step && op == OpLoad && !bad_len && idx == LW'(1)) begin
      if (wr_en) sym_mem[NW'(nodes_used)] <= sym;
      else if (child != '0) sym_mem[child] <= sym;
    end
    if (cmd.rd) begin
      rd_l <= left_mem[rd_addr];
      rd_r <= right_mem[rd_addr];
    end
  end
  logic [SW-1:0] rd_sym;
  always_ff @(posedge clk) begin
    if (cmd.rd) rd_sym <= sym_mem[rd_addr];
  end
  assign nx_l = rd_l;
  assign nx_r = rd_r;
  assign leaf = (nx_l == '0) && (nx_r == '0);
  assign last_bit = (idx == LW'(cnt) - LW'(1));

  always_comb begin
    wr_en = 1'b0;
    wr_right = bit_now;
    wr_addr = node;
    wr_data = NW'(nodes_used);
    if (cmd.step && op == OpLoad && !bad_len && idx != '0 && child == '0 && !full)
      wr_en = 1'b1;
  end

  // step logic
  logic done;
  always_comb begin
    done = 1'b0;
    if (cmd.step) begin
      unique case (op)
        OpLoad:
          done = bad_len || idx == LW'(1) || (child == '0 && full);
        OpDecode: begin
          if (fin) done = 1'b1;
          else if (!lookahead) done = (cnt == '0) || (child == '0 && !held_valid);
          else done = last_bit && !(leaf && held_valid);
        end
        default: done = 1'b1;
      endcase
    end
  end
  assign stat.done = done;

  // result of this step; a decode sends a symbol only once the next result
  // or the end of the walk is known, so tlast lands on the final one
  logic res_valid_next;
  logic [1:0] res_status_next;
  logic [7:0] res_symbol_next;
  always_comb begin
    res_valid_next = 1'b0;
    res_status_next = StError;
    res_symbol_next = '0;
    if (cmd.step) begin
      unique case (op)
        OpLoad: begin
          if (bad_len || (child == '0 && full)) begin
            res_valid_next = 1'b1;
          end else if (idx == LW'(1)) begin
            res_valid_next = 1'b1;
            res_status_next = StAccepted;
          end
        end
        OpDecode: begin
          if (fin) begin
            res_valid_next = 1'b1;
            res_status_next = held_status;
            res_symbol_next = 8'(held_symbol);
          end else if (!lookahead) begin
            if (cnt == '0) begin
              res_valid_next = 1'b1;
              res_status_next = StNone;
            end else if (child == '0) begin
              res_valid_next = 1'b1;
              if (held_valid) begin
                res_status_next = held_status;
                res_symbol_next = 8'(held_symbol);
              end
            end
          end else if (leaf) begin
            if (held_valid) begin
              res_valid_next = 1'b1;
              res_status_next = held_status;
              res_symbol_next = 8'(held_symbol);
            end else if (last_bit) begin
              res_valid_next = 1'b1;
              res_status_next = StSymbol;
              res_symbol_next = 8'(rd_sym);
            end
          end else if (last_bit) begin
            res_valid_next = 1'b1;
            res_status_next = held_valid ? held_status : StNone;
            res_symbol_next = held_valid ? 8'(held_symbol) : 8'd0;
          end
        end
        OpRestart: begin
          res_valid_next = 1'b1;
          res_status_next = StAccepted;
        end
        default: res_valid_next = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_node <= '0;
      nodes_used <= CW'(1);
      res_valid <= 1'b0;
      lookahead <= 1'b0;
      held_valid <= 1'b0;
      fin <= 1'b0;
    end else begin
      res_valid <= res_valid_next;
      if (cmd.restart) walk_node <= '0;
      if (cmd.capture) begin
        op <= operation;
        sym <= SW'(symbol);
        bits <= code_bits;
        len <= LW'(code_length);
        dbyte <= data_byte;
        cnt <= valid_bits > 4'd8 ? 4'd8 : valid_bits;
        idx <= (operation == OpLoad) ? LW'(code_length) : '0;
        node <= (operation == OpLoad) ? '0 : walk_node;
        lookahead <= 1'b0;
        held_valid <= 1'b0;
        fin <= 1'b0;
      end else if (cmd.step) begin
        res_status <= res_status_next;
        res_symbol <= res_symbol_next;
        res_last <= done;
        unique case (op)
          OpLoad: begin
            if (!bad_len && !(child == '0 && full)) begin
              if (wr_en) begin
                node <= NW'(nodes_used);
                nodes_used <= nodes_used + 1'b1;
              end else begin
                node <= child;
              end
              idx <= idx - 1'b1;
            end
          end
          OpDecode: begin
            if (!fin) begin
              if (!lookahead) begin
                if (cnt != '0) begin
                  if (child == '0) begin
                    walk_node <= '0;
                    // held symbol goes out now, the error follows as the last
                    if (held_valid) begin
                      held_status <= StError;
                      held_symbol <= '0;
                      fin <= 1'b1;
                    end
                  end else begin
                    lookahead <= 1'b1;
                  end
                end
              end else begin
                // rd_l/rd_r/rd_sym now describe the child held in pend
                lookahead <= 1'b0;
                idx <= idx + 1'b1;
                if (leaf) begin
                  node <= '0;
                  walk_node <= '0;
                  if (held_valid || !last_bit) begin
                    held_valid <= 1'b1;
                    held_status <= StSymbol;
                    held_symbol <= rd_sym;
                  end
                  if (held_valid && last_bit) fin <= 1'b1;
                end else begin
                  node <= pend;
                  walk_node <= pend;
                end
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  // child captured by the first-read decode step that precedes the lookahead read
  always_ff @(posedge clk) begin
    if (cmd.step && op == OpDecode && !lookahead) pend <= child;
  end
endmodule

FILE: rtl/core/htd_ctrl.sv
module htd_ctrl
  import htd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [1:0] operation,
  input  logic out_free,
  input  htd_stat_t stat,
  output htd_cmd_t cmd
);
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_STEP = 3'd3;
  localparam logic [2:0] S_WAIT = 3'd4;

  logic [2:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else state <= state_next;
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (operation == OpRestart) cmd.restart = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.rd = 1'b1;
        state_next = S_WAIT;
      end
      S_WAIT: begin
        if (out_free) state_next = S_STEP;
      end
      S_STEP: begin
        cmd.step = 1'b1;
        state_next = stat.done ? S_IDLE : S_READ;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

FILE: rtl/core/huffman_tree_decoder_top.sv
// huffman tree-walk decoder. s_tuser selects a load, decode or restart transaction and
// s_tdata carries its fields; m_tdata/m_tuser return one or more results (tlast on the
// final one). after a transaction is accepted, every node-table step passes through the
// read, wait (for the read data and a free output register) and step states. a load uses
// one step per codeword bit; a bad length, a restart or an unknown operation use one
// step. a decode uses two steps per bit (node read, then a child read for the leaf test).
// a decoded symbol is held back until the next result or the end of the byte is known,
// and when both are due at the end one more step flushes them. every step also waits
// while an untaken result sits in the output register. after reset a clearing pass over
// the node table runs before the first transaction is taken.
module huffman_tree_decoder_top
  import htd_pkg::*;
#(
  parameter int NODE_COUNT = NodeCountDef,
  parameter int MAX_CODE_LENGTH = MaxCodeLengthDef,
  parameter int SYMBOL_WIDTH = SymbolWidthDef
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [47:0] s_tdata,  // symbol, code_bits, code_length, data_byte, valid_bits
  input  logic [1:0] s_tuser,   // operation
  output logic m_tvalid,
  input  logic m_tready,
  output logic [7:0] m_tdata,   // decoded_symbol
  output logic [1:0] m_tuser,   // status
  output logic m_tlast
);
  htd_cmd_t cmd;
  htd_stat_t stat;
  logic res_valid, res_last;
  logic [1:0] res_status;
  logic [7:0] res_symbol;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
      m_tdata <= res_symbol;
      m_tuser <= res_status;
      m_tlast <= res_last;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  htd_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(s_tvalid), .in_ready(s_tready),
    .operation(s_tuser),
    .out_free(!m_tvalid || m_tready),
    .stat, .cmd
  );

  htd_datapath #(
    .NODE_COUNT(NODE_COUNT), .MAX_CODE_LENGTH(MAX_CODE_LENGTH),
    .SYMBOL_WIDTH(SYMBOL_WIDTH)
  ) u_dp (
    .clk, .rst, .cmd, .stat,
    .operation(s_tuser), .symbol(s_tdata[7:0]), .code_bits(s_tdata[23:8]),
    .code_length(s_tdata[28:24]), .data_byte(s_tdata[36:29]), .valid_bits(s_tdata[40:37]),
    .res_valid, .res_status, .res_symbol, .res_last
  );
endmodule
